// ===== src/bbcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcm_pkg: shared types and constants for the clipped box blur
// Store geometry, register indexes and the request payload types.
// ----------------------------------------------------------------------------
package bbcm_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxRadius  = 7;
  localparam int StoreRows  = 2 * MaxRadius + 2;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int SRowW      = $clog2(StoreRows);
  localparam int AddrW      = SRowW + ColW;
  localparam int Depth      = StoreRows * MaxWidth;
  localparam int PixW       = 24;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;
  // window sum: 225 * 255 fits in 16 bits
  localparam int SumW       = 16;
  localparam int CntW       = 8;

  localparam logic [CfgIdxW-1:0] RegWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRadius = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFirst  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegEnd    = 3'd4;

  localparam logic CmdPixel = 1'b0;
  localparam logic CmdFlush = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;
    logic [15:0] out_row;
    logic [9:0]  out_column;
    logic        frame_done;
  } out_req_t;

  // divider handshake
  typedef struct packed {
    logic            start;
    logic [SumW-1:0] num;
    logic [CntW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quot;
  } div_rsp_t;

endpackage

// ===== src/bbcm_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcm_stream_if: valid/ready channel
// Carries one request of a fixed payload type: in_req_t or out_req_t.
// ----------------------------------------------------------------------------
interface bbcm_in_if;
  logic              valid;
  logic              ready;
  bbcm_pkg::in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bbcm_out_if;
  logic               valid;
  logic               ready;
  bbcm_pkg::out_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/box_blur_clipped_mean.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_clipped_mean: clipped-border box blur over a streamed BGR frame
// Line store, window walker and shared divider under one sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  carries pixel requests (cmd=0) or flush ticks (cmd=1) in raster
//   order; out_if carries blurred or passed pixels with row, column and a
//   frame_done mark on the last pixel. Registers are written through
//   cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only while
//   the block is idle, which the block does not enforce. A write to index 0
//   to 4 restarts the frame. One request is taken at a time. A request
//   that releases nothing passes through the check state and frees the
//   input. A passed row pixel is read from the store in the pass state and
//   registered in the output state. A blurred pixel walks its clipped
//   window through the single store port, one pixel per cycle, then runs
//   the bit-serial divider once per channel before the output state
//   registers it. The next request is taken once the result has left, so
//   the block takes no new request while one is still in flight.
//   Reset clears counters and loads the default registers; the store needs
//   no clearing. A stalled receiver holds the output register and the block
//   takes no new request until it is drained.
// ----------------------------------------------------------------------------
module box_blur_clipped_mean (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bbcm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [bbcm_pkg::CfgDataW-1:0]    cfg_data_i,
  bbcm_in_if.sink                          in_if,
  bbcm_out_if.source                       out_if
);
  typedef enum logic [2:0] {
    StIdle, StCheck, StWalk, StDiv, StPass, StOut
  } state_e;

  localparam int AW = bbcm_pkg::AddrW;
  localparam int CW = bbcm_pkg::ColW;

  state_e state_q;
  logic [10:0] width_q;
  logic [15:0] height_q, first_q, end_q;
  logic [2:0]  radius_q;
  logic [15:0] in_row_q, out_row_q;
  logic [CW-1:0] in_col_q, out_col_q;

  logic [15:0] y_q, y1_q;
  logic [CW-1:0] x_q, x0_q, x1_q;
  logic        rd_valid_q, walk_last_q;
  logic [bbcm_pkg::SumW-1:0] sum_q [3];
  logic [bbcm_pkg::CntW-1:0] cnt_q;
  logic [1:0]  ch_q;
  logic [7:0]  px_q [3];
  logic        div_started_q;
  bbcm_pkg::out_req_t out_q;
  logic        out_valid_q;

  // effective configuration
  logic [CW:0]  w_eff;
  logic [15:0]  h_eff;
  logic [2:0]   r_eff;
  assign w_eff = (width_q == 11'd0) ? (CW+1)'(1) :
                 (width_q > 11'(bbcm_pkg::MaxWidth)) ? (CW+1)'(bbcm_pkg::MaxWidth) :
                 width_q[CW:0];
  assign h_eff = (height_q == 16'd0) ? 16'd1 : height_q;
  assign r_eff = radius_q;

  logic [15:0] h_last;
  logic [CW-1:0] w_last;
  assign h_last = h_eff - 16'd1;
  assign w_last = CW'(w_eff - (CW+1)'(1));

  // readiness of the next output
  logic        all_in;
  logic [16:0] orow_r;
  logic [CW:0] ocol_r;
  logic [15:0] need_row;
  logic [CW-1:0] need_col;
  logic        out_ready_now;
  assign all_in   = in_row_q >= h_eff;
  assign orow_r   = {1'b0, out_row_q} + 17'(r_eff);
  assign ocol_r   = {1'b0, out_col_q} + (CW+1)'(r_eff);
  assign need_row = (orow_r > {1'b0, h_last}) ? h_last : orow_r[15:0];
  assign need_col = (ocol_r > {1'b0, w_last}) ? w_last : ocol_r[CW-1:0];
  assign out_ready_now = all_in || (in_row_q > need_row) ||
                         (in_row_q == need_row && in_col_q > need_col);

  logic in_range;
  assign in_range = (out_row_q >= first_q) && (out_row_q < end_q);

  // store slot: row mod StoreRows, a power of two, so the low row bits
  function automatic logic [bbcm_pkg::SRowW-1:0] row_slot(input logic [15:0] r);
    return bbcm_pkg::SRowW'(r % bbcm_pkg::StoreRows);
  endfunction

  // window bounds
  logic [15:0]   win_r0;
  logic [CW-1:0] win_c0;
  assign win_r0 = (out_row_q >= 16'(r_eff)) ? out_row_q - 16'(r_eff) : 16'd0;
  assign win_c0 = (out_col_q >= CW'(r_eff)) ? out_col_q - CW'(r_eff) : '0;

  // store port
  logic          st_we;
  logic [AW-1:0] st_addr;
  logic [23:0]   st_rdata;
  logic          accept;
  assign accept = in_if.valid && in_if.ready;
  assign st_we  = accept && (in_if.data.cmd == bbcm_pkg::CmdPixel) && !all_in;
  always_comb begin
    if (st_we) begin
      st_addr = {row_slot(in_row_q), in_col_q};
    end else if (state_q == StWalk) begin
      st_addr = {row_slot(y_q), x_q};
    end else begin
      st_addr = {row_slot(out_row_q), out_col_q};
    end
  end

  bbcm_ram #(.Width(bbcm_pkg::PixW), .Depth(bbcm_pkg::Depth)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .addr_i  (st_addr),
    .wdata_i ({in_if.data.in_red, in_if.data.in_green, in_if.data.in_blue}),
    .rdata_o (st_rdata)
  );

  // divider
  bbcm_pkg::div_req_t div_req;
  bbcm_pkg::div_rsp_t div_rsp;
  assign div_req.start = (state_q == StDiv) && !div_started_q;
  assign div_req.num   = sum_q[ch_q];
  assign div_req.den   = (cnt_q == '0) ? 8'd1 : cnt_q;
  bbcm_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  assign in_if.ready  = (state_q == StIdle) && !out_valid_q;
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  logic frame_end;
  assign frame_end = (out_row_q == h_last) && (out_col_q == w_last);

  // sequencer and registered state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      width_q     <= 11'd640;
      height_q    <= 16'd480;
      radius_q    <= 3'd1;
      first_q     <= 16'd0;
      end_q       <= 16'd480;
      in_row_q    <= '0;
      in_col_q    <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_valid_q <= 1'b0;
      rd_valid_q  <= 1'b0;
      walk_last_q <= 1'b0;
      div_started_q <= 1'b0;
      ch_q        <= '0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bbcm_pkg::RegWidth:  width_q  <= cfg_data_i[10:0];
          bbcm_pkg::RegHeight: height_q <= cfg_data_i;
          bbcm_pkg::RegRadius: radius_q <= cfg_data_i[2:0];
          bbcm_pkg::RegFirst:  first_q  <= cfg_data_i;
          bbcm_pkg::RegEnd:    end_q    <= cfg_data_i;
          default: ;
        endcase
        if (cfg_idx_i <= bbcm_pkg::RegEnd) begin
          in_row_q  <= '0;
          in_col_q  <= '0;
          out_row_q <= '0;
          out_col_q <= '0;
        end
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (st_we) begin
              if ({1'b0, in_col_q} + (CW+1)'(1) >= w_eff) begin
                in_col_q <= '0;
                in_row_q <= in_row_q + 16'd1;
              end else begin
                in_col_q <= in_col_q + 1'b1;
              end
            end
            state_q <= StCheck;
          end
        end
        StCheck: begin
          if (!out_ready_now) begin
            state_q <= StIdle;
          end else if (in_range) begin
            y_q  <= win_r0;
            y1_q <= need_row;
            x_q  <= win_c0;
            x0_q <= win_c0;
            x1_q <= need_col;
            sum_q[0] <= '0;
            sum_q[1] <= '0;
            sum_q[2] <= '0;
            cnt_q <= '0;
            rd_valid_q  <= 1'b0;
            walk_last_q <= 1'b0;
            state_q <= StWalk;
          end else begin
            rd_valid_q <= 1'b0;
            state_q <= StPass;
          end
        end
        StWalk: begin
          // accumulate the word read last cycle
          if (rd_valid_q) begin
            sum_q[0] <= sum_q[0] + 16'(st_rdata[7:0]);
            sum_q[1] <= sum_q[1] + 16'(st_rdata[15:8]);
            sum_q[2] <= sum_q[2] + 16'(st_rdata[23:16]);
            cnt_q    <= cnt_q + 1'b1;
          end
          if (walk_last_q) begin
            rd_valid_q  <= 1'b0;
            walk_last_q <= 1'b0;
            ch_q <= '0;
            div_started_q <= 1'b0;
            state_q <= StDiv;
          end else begin
            rd_valid_q <= 1'b1;
            if (x_q == x1_q) begin
              x_q <= x0_q;
              if (y_q == y1_q) begin
                walk_last_q <= 1'b1;
              end else begin
                y_q <= y_q + 16'd1;
              end
            end else begin
              x_q <= x_q + 1'b1;
            end
          end
        end
        StDiv: begin
          if (div_rsp.done) begin
            px_q[ch_q] <= div_rsp.quot;
            div_started_q <= 1'b0;
            if (ch_q == 2'd2) begin
              state_q <= StOut;
            end else begin
              ch_q <= ch_q + 2'd1;
            end
          end else begin
            div_started_q <= 1'b1;
          end
        end
        StPass: begin
          // the read address is presented first, then the registered data is taken
          if (rd_valid_q) begin
            px_q[0] <= st_rdata[7:0];
            px_q[1] <= st_rdata[15:8];
            px_q[2] <= st_rdata[23:16];
            state_q <= StOut;
          end else begin
            rd_valid_q <= 1'b1;
          end
        end
        StOut: begin
          out_valid_q <= 1'b1;
          out_q.out_blue   <= px_q[0];
          out_q.out_green  <= px_q[1];
          out_q.out_red    <= px_q[2];
          out_q.out_row    <= out_row_q;
          out_q.out_column <= out_col_q;
          out_q.frame_done <= frame_end;
          rd_valid_q <= 1'b0;
          if (frame_end) begin
            in_row_q  <= '0;
            in_col_q  <= '0;
            out_row_q <= '0;
            out_col_q <= '0;
          end else if (out_col_q == w_last) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + 16'd1;
          end else begin
            out_col_q <= out_col_q + 1'b1;
          end
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  // no new request while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_if.ready) else $error("request taken over pending result");
  // store write only from the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |-> state_q == StIdle) else $error("store write outside idle");
  // window count never exceeds the largest window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> cnt_q <= 8'd225) else $error("window count overflow");
  // a result is only loaded from the output state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StOut) else $error("stray result");
`endif
endmodule

// ===== src/bbcm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcm_ram: generic single-port RAM
// One address per cycle, written and read together; registered read data.
// ----------------------------------------------------------------------------
module bbcm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write the addressed word when enabled and always read it
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== src/bbcm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcm_div: restoring divider
// One quotient bit per cycle; the quotient is cut to 8 bits.
// ----------------------------------------------------------------------------
module bbcm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bbcm_pkg::div_req_t  req_i,
  output bbcm_pkg::div_rsp_t  rsp_o
);
  localparam int N = bbcm_pkg::SumW;
  localparam int StepW = $clog2(N + 1);

  logic [N-1:0]             quo_q, quo_d;
  logic [bbcm_pkg::CntW:0]  rem_q, rem_d;
  logic [bbcm_pkg::CntW-1:0] den_q, den_d;
  logic [StepW-1:0]         step_q, step_d;
  logic                     busy_q, busy_d, done_q, done_d;
  logic [bbcm_pkg::CntW+1:0] trial;

  // shift one numerator bit in, subtract when it fits
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[N-1]} - {2'b00, den_q};
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      step_d = StepW'(N);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[bbcm_pkg::CntW+1]) begin
        rem_d = trial[bbcm_pkg::CntW:0];
        quo_d = {quo_q[N-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[bbcm_pkg::CntW-1:0], quo_q[N-1]};
        quo_d = {quo_q[N-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // hold divider state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q[7:0];
endmodule
